>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// prop must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
// cond must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

>>> hdl/cobs_enc_pkg.sv
// ----------------------------------------------------------------------------
// cobs_enc_pkg
// Types and constants shared by the COBS frame encoder.
// ----------------------------------------------------------------------------
package cobs_enc_pkg;

	localparam int MAX_RESULTS = 4;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
	localparam int IDX_W       = $clog2(MAX_RESULTS);
	localparam int PADDR_W     = 3;

	localparam logic [7:0]  CODE_MAX      = 8'hFF;
	localparam logic [7:0]  CODE_START    = 8'h01;
	localparam logic [15:0] CAP_RESET     = 16'd512;
	localparam logic [15:0] CAP_MIN       = 16'd2;
	localparam logic [15:0] WP_RESET      = 16'd1;
	localparam logic [15:0] CP_RESET      = 16'd0;

	// register index taken from paddr[2]
	localparam logic REG_CAPACITY = 1'b0;

	typedef struct packed {
		logic [15:0] write_offset;
		logic [7:0]  write_value;
		logic        frame_done;
		logic [15:0] frame_length;
		logic        overflow;
		logic        step_last;
	} result_t;

	typedef struct packed {
		logic [CNT_W-1:0]              count;
		result_t [MAX_RESULTS-1:0]     res;
	} batch_t;

endpackage

>>> hdl/cobs_byte_if.sv
// ----------------------------------------------------------------------------
// cobs_byte_if
// Payload byte channel: one raw byte per request with a last-byte flag.
// ----------------------------------------------------------------------------
interface cobs_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source(output valid, output data_byte, output last_byte, input ready);
	modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

>>> hdl/cobs_write_if.sv
// ----------------------------------------------------------------------------
// cobs_write_if
// Buffer write channel: offset/value writes plus frame status per request.
// ----------------------------------------------------------------------------
interface cobs_write_if;
	logic        valid;
	logic        ready;
	logic [15:0] write_offset;
	logic [7:0]  write_value;
	logic        frame_done;
	logic [15:0] frame_length;
	logic        overflow;
	logic        step_last;

	modport source(
		output valid, output write_offset, output write_value, output frame_done,
		output frame_length, output overflow, output step_last, input ready
	);
	modport sink(
		input valid, input write_offset, input write_value, input frame_done,
		input frame_length, input overflow, input step_last, output ready
	);
endinterface

>>> hdl/cobs_enc_step.sv
// ----------------------------------------------------------------------------
// cobs_enc_step
// Frame state (write position, code slot, running code, discard flag) and
// the per-byte encode logic producing up to four buffer writes.
// ----------------------------------------------------------------------------
module cobs_enc_step (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  commit,
	input  logic [7:0]            data_byte,
	input  logic                  last_byte,
	input  logic [15:0]           capacity,
	output cobs_enc_pkg::batch_t  batch
);

	logic [15:0] wp_q;
	logic [15:0] cp_q;
	logic [7:0]  rc_q;
	logic        disc_q;

	logic [16:0] nwp;
	logic [15:0] ncp;
	logic [7:0]  nrc;
	logic        ndisc;
	logic        clr;
	logic        ovf;
	logic [2:0]  n;
	logic [16:0] cap17;
	logic [16:0] wp1;
	logic [16:0] wp2;
	logic [7:0]  rc_inc;

	function automatic cobs_enc_pkg::result_t mk_res(
		input logic [15:0] off,
		input logic [7:0]  val
	);
		cobs_enc_pkg::result_t r;
		r = '0;
		r.write_offset = off;
		r.write_value  = val;
		return r;
	endfunction

	assign cap17  = {1'b0, capacity};
	assign wp1    = {1'b0, wp_q} + 17'd1;
	assign wp2    = {1'b0, wp_q} + 17'd2;
	assign rc_inc = rc_q + 8'd1;

	always_comb begin
		batch = '0;
		n     = 3'd0;
		ovf   = 1'b0;
		clr   = 1'b0;
		nwp   = {1'b0, wp_q};
		ncp   = cp_q;
		nrc   = rc_q;
		ndisc = disc_q;
		if (disc_q) begin
			clr = last_byte;
		end else begin
			if (capacity < cobs_enc_pkg::CAP_MIN) begin
				ovf = 1'b1;
			end else if (data_byte == 8'd0) begin
				batch.res[0] = mk_res(cp_q, rc_q);
				n   = 3'd1;
				ncp = wp_q;
				nwp = wp1;
				nrc = cobs_enc_pkg::CODE_START;
				ovf = (wp1 >= cap17);
			end else if ({1'b0, wp_q} >= cap17) begin
				ovf = 1'b1;
			end else begin
				batch.res[0] = mk_res(wp_q, data_byte);
				n   = 3'd1;
				nwp = wp1;
				nrc = rc_inc;
				if (rc_inc == cobs_enc_pkg::CODE_MAX) begin
					batch.res[1] = mk_res(cp_q, cobs_enc_pkg::CODE_MAX);
					n   = 3'd2;
					ncp = wp1[15:0];
					nwp = wp2;
					nrc = cobs_enc_pkg::CODE_START;
					ovf = (wp2 >= cap17);
				end
			end
			if (!ovf && last_byte) begin
				batch.res[n[1:0]] = mk_res(ncp, nrc);
				if (nwp >= cap17) begin
					ovf = 1'b1;
				end else begin
					batch.res[2'(n + 3'd1)] = mk_res(nwp[15:0], 8'd0);
					batch.res[2'(n + 3'd1)].frame_done   = 1'b1;
					batch.res[2'(n + 3'd1)].frame_length = nwp[15:0] + 16'd1;
					n   = n + 3'd2;
					clr = 1'b1;
				end
			end
			if (ovf) begin
				batch.res = '0;
				batch.res[0].frame_done = 1'b1;
				batch.res[0].overflow   = 1'b1;
				n     = 3'd1;
				clr   = last_byte;
				ndisc = !last_byte;
			end
			if (n != 3'd0) begin
				batch.res[2'(n - 3'd1)].step_last = 1'b1;
			end
		end
		batch.count = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= cobs_enc_pkg::WP_RESET;
			cp_q   <= cobs_enc_pkg::CP_RESET;
			rc_q   <= cobs_enc_pkg::CODE_START;
			disc_q <= 1'b0;
		end else if (commit) begin
			if (clr) begin
				wp_q   <= cobs_enc_pkg::WP_RESET;
				cp_q   <= cobs_enc_pkg::CP_RESET;
				rc_q   <= cobs_enc_pkg::CODE_START;
				disc_q <= 1'b0;
			end else begin
				wp_q   <= nwp[15:0];
				cp_q   <= ncp;
				rc_q   <= nrc;
				disc_q <= ndisc;
			end
		end
	end

endmodule

>>> hdl/cobs_frame_encoder_core.sv
// A byte accepted on raw_bytes is registered in s1; its writes are then registered
// in the result buffer before they are offered on buf_writes. Throughput: one byte
// per cycle while each byte makes at most one write and buf_writes is ready; a byte
// making several writes (up to four) holds the result buffer until its last is taken.
// Reset: asynchronous, clears the frame state, empties the pipeline, sets cap_q to 512.
// ----------------------------------------------------------------------------
// cobs_frame_encoder_core
// Streaming COBS encoder issuing buffer writes with code byte write-back,
// overflow detection against a programmable capacity, and an APB register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cobs_frame_encoder_core (
	input  logic                               clk,
	input  logic                               arst_n,
	cobs_byte_if.sink                          raw_bytes,
	cobs_write_if.source                       buf_writes,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [cobs_enc_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);

	logic [15:0] cap_q;

	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        last_s1;

	cobs_enc_pkg::result_t              res_q [cobs_enc_pkg::MAX_RESULTS];
	logic [cobs_enc_pkg::CNT_W-1:0]     cnt_q;
	logic [cobs_enc_pkg::IDX_W-1:0]     idx_q;

	cobs_enc_pkg::batch_t batch;
	cobs_enc_pkg::result_t cur;
	logic buf_free;
	logic load;
	logic take;
	logic cap_sel;

	// APB register
	assign pready  = 1'b1;
	assign cap_sel = (paddr[2] == cobs_enc_pkg::REG_CAPACITY);
	assign prdata  = cap_sel ? {16'd0, cap_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= cobs_enc_pkg::CAP_RESET;
		end else if (psel && penable && pwrite && cap_sel) begin
			cap_q <= pwdata[15:0];
		end
	end

	// request handshakes
	assign take     = buf_writes.valid && buf_writes.ready;
	assign buf_free = (cnt_q == '0) || ((cnt_q == cobs_enc_pkg::CNT_W'(1)) && buf_writes.ready);
	assign load     = valid_s1 && buf_free;
	assign raw_bytes.ready = !valid_s1 || load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (raw_bytes.ready) begin
			valid_s1 <= raw_bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (raw_bytes.valid && raw_bytes.ready) begin
			data_s1 <= raw_bytes.data_byte;
			last_s1 <= raw_bytes.last_byte;
		end
	end

	cobs_enc_step u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.commit    (load),
		.data_byte (data_s1),
		.last_byte (last_s1),
		.capacity  (cap_q),
		.batch     (batch)
	);

	// result buffer, drained one write per request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			cnt_q <= batch.count;
			idx_q <= '0;
		end else if (take) begin
			cnt_q <= cnt_q - cobs_enc_pkg::CNT_W'(1);
			idx_q <= idx_q + cobs_enc_pkg::IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < cobs_enc_pkg::MAX_RESULTS; i++) begin
				res_q[i] <= batch.res[i];
			end
		end
	end

	assign cur = res_q[idx_q];

	assign buf_writes.valid        = (cnt_q != '0);
	assign buf_writes.write_offset = cur.write_offset;
	assign buf_writes.write_value  = cur.write_value;
	assign buf_writes.frame_done   = cur.frame_done;
	assign buf_writes.frame_length = cur.frame_length;
	assign buf_writes.overflow     = cur.overflow;
	assign buf_writes.step_last    = cur.step_last;

	`ASSERT_NEVER(a_cnt_range, clk, arst_n, cnt_q > cobs_enc_pkg::CNT_W'(cobs_enc_pkg::MAX_RESULTS))
	`ASSERT_ALWAYS(a_last_is_final, clk, arst_n, (buf_writes.valid && (cnt_q == cobs_enc_pkg::CNT_W'(1))) |-> buf_writes.step_last)
	`ASSERT_ALWAYS(a_ovf_alone, clk, arst_n, (buf_writes.valid && buf_writes.overflow) |-> (buf_writes.frame_done && buf_writes.step_last && (cnt_q == cobs_enc_pkg::CNT_W'(1))))

endmodule
